/* rtl/kab_pkg.sv */
// ----------------------------------------------------------------------------
// kab_pkg
// Shared types, constants and helpers for the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
package kab_pkg;

    localparam int NUM_CHANNELS = 3;
    localparam int FRAC_BITS    = 20;
    localparam int CH_W         = 2;
    localparam int DT_W         = 21;
    localparam int CFG_IDX_W    = 2;

    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

    localparam logic [30:0] ANGLE_NOISE_RST = 31'(((1 << FRAC_BITS) + 500) / 1000);
    localparam logic [30:0] BIAS_NOISE_RST  = 31'(((1 << FRAC_BITS) * 5 + 500) / 1000);
    localparam logic [30:0] MEAS_NOISE_RST  = 31'((1 << FRAC_BITS) / 2);
    localparam logic signed [31:0] OBS_GAIN_RST = ONE_Q;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_NOISE = 2'd0,
        CFG_BIAS_NOISE  = 2'd1,
        CFG_MEAS_NOISE  = 2'd2,
        CFG_OBS_GAIN    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic signed [31:0] angle_meas;
        logic signed [31:0] gyro_meas;
        logic [DT_W-1:0]    step_time;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] angle_est;
        logic signed [31:0] rate_est;
    } out_beat_t;

    // result = sat(c +/- sat(round(x*y)))
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [33:0] c;
        logic               neg;
    } mac_op_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

endpackage

/* rtl/kab_mac.sv */
// ----------------------------------------------------------------------------
// kab_mac
// Shared fixed point multiply, round, saturate and accumulate unit.
// ----------------------------------------------------------------------------
module kab_mac
    import kab_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  mac_op_t            op,
    output logic               done,
    output logic signed [31:0] result
);

    logic signed [63:0] prod_reg;
    logic signed [33:0] c_reg;
    logic               neg_reg;
    logic               v1_reg;
    logic               done_reg;
    logic signed [31:0] result_reg;

    logic signed [63:0] rnd;
    logic signed [63:0] shr;
    logic signed [31:0] q;
    logic signed [34:0] term;
    logic signed [34:0] acc;

    always_comb begin
        rnd  = prod_reg + (64'sd1 <<< (FRAC_BITS - 1));
        shr  = rnd >>> FRAC_BITS;
        q    = sat32(shr);
        term = neg_reg ? -{{3{q[31]}}, q} : {{3{q[31]}}, q};
        acc  = {c_reg[33], c_reg} + term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
        if (start) begin
            prod_reg <= 64'(op.x) * 64'(op.y);
            c_reg    <= op.c;
            neg_reg  <= op.neg;
        end
        if (v1_reg) begin
            result_reg <= sat32({{29{acc[34]}}, acc});
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/kab_div.sv */
// ----------------------------------------------------------------------------
// kab_div
// Bit-serial restoring divider: sat((num << FRAC_BITS) / den), den > 0.
// ----------------------------------------------------------------------------
module kab_div
    import kab_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic [30:0]        den,
    output logic               done,
    output logic signed [31:0] quot
);

    localparam int DVD_W = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic               busy_reg;
    logic               fin_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [DVD_W-1:0]   q_reg;
    logic [30:0]        rem_reg;
    logic [30:0]        den_reg;
    logic               neg_reg;
    logic signed [31:0] quot_reg;

    logic [31:0]        rem_sh;
    logic               ge;
    logic [31:0]        rem_sub;
    logic [31:0]        mag;
    logic signed [63:0] qs;

    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
        mag     = num[31] ? 32'(-num) : 32'(num);
        qs      = neg_reg ? -64'({{(64-DVD_W){1'b0}}, q_reg})
                          : 64'({{(64-DVD_W){1'b0}}, q_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
        if (start) begin
            cnt_reg <= '0;
            dvd_reg <= {mag, {FRAC_BITS{1'b0}}};
            q_reg   <= '0;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[31];
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            q_reg   <= {q_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? rem_sub[30:0] : rem_sh[30:0];
        end
        if (fin_reg) begin
            quot_reg <= sat32(qs);
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* rtl/kalman_angle_bias_filter.sv */
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// Per-channel two-state (angle, gyro bias) Kalman filter, Q12.20 fixed point.
// ----------------------------------------------------------------------------
// One input beat gives one result beat. An item runs 13 multiply-accumulate
// steps on the one shared multiplier when the correction is skipped, and 20
// such steps plus two bit-serial gain divisions otherwise. s_ready is high only
// while no item is in work; a finished result waits in the output register and
// does not block acceptance of the next item, which waits in S_DONE until the
// register is free. A channel number of NUM_CHANNELS or more gives a zero
// result.
module kalman_angle_bias_filter
    import kab_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_beat_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_beat_t            m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [31:0]          cfg_wdata
);

    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_DIV, S_DONE} state_t;

    typedef enum logic [4:0] {
        ST_GDIFF, ST_APRED, ST_PD0, ST_PD1, ST_P00, ST_P01, ST_P10, ST_P11,
        ST_ERR, ST_PCT0, ST_PCT1, ST_E, ST_K0, ST_K1, ST_T1,
        ST_C00, ST_C01, ST_C10, ST_C11, ST_CA, ST_CB, ST_RATE
    } step_t;

    state_t state_reg;
    step_t  step_reg;

    logic [30:0]        angle_noise_reg, bias_noise_reg, meas_noise_reg;
    logic signed [31:0] obs_gain_reg;

    logic signed [31:0] est_angle_reg [NUM_CHANNELS];
    logic signed [31:0] est_bias_reg  [NUM_CHANNELS];
    logic signed [31:0] cov_aa_reg    [NUM_CHANNELS];
    logic signed [31:0] cov_ab_reg    [NUM_CHANNELS];
    logic signed [31:0] cov_ba_reg    [NUM_CHANNELS];
    logic signed [31:0] cov_bb_reg    [NUM_CHANNELS];

    logic [CH_W-1:0]    ch_reg;
    logic signed [31:0] meas_reg, gyro_reg, dt_reg;
    logic signed [31:0] a_reg, b_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] t0_reg, t1_reg, err_reg, pct0_reg, pct1_reg, e_reg;
    logic signed [31:0] k0_reg, k1_reg, tt_reg, rate_reg;
    logic               zero_reg;

    logic               m_valid_reg;
    out_beat_t          m_data_reg;

    mac_op_t            mac_op;
    logic               mac_start, mac_done;
    logic signed [31:0] mac_res;
    logic               div_start, div_done;
    logic signed [31:0] div_num, div_q;

    logic               in_fire;
    logic               ch_ok;
    logic               out_load;

    assign s_ready  = (state_reg == S_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign ch_ok    = 32'(s_data.channel) < NUM_CHANNELS;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    assign mac_start = (state_reg == S_ISSUE) && step_reg != ST_K0 && step_reg != ST_K1;
    assign div_start = (state_reg == S_ISSUE) && (step_reg == ST_K0 || step_reg == ST_K1);
    assign div_num   = (step_reg == ST_K0) ? pct0_reg : pct1_reg;

    always_comb begin
        mac_op = '0;
        unique case (step_reg)
            ST_GDIFF: mac_op = '{b_reg, ONE_Q, sx34(gyro_reg), 1'b1};
            ST_APRED: mac_op = '{t0_reg, dt_reg, sx34(a_reg), 1'b0};
            ST_PD0:   mac_op = '{p10_reg, ONE_Q,
                                 34'({1'b0, angle_noise_reg}) - sx34(p01_reg), 1'b1};
            ST_PD1:   mac_op = '{p11_reg, ONE_Q, 34'sd0, 1'b1};
            ST_P00:   mac_op = '{t0_reg, dt_reg, sx34(p00_reg), 1'b0};
            ST_P01:   mac_op = '{t1_reg, dt_reg, sx34(p01_reg), 1'b0};
            ST_P10:   mac_op = '{t1_reg, dt_reg, sx34(p10_reg), 1'b0};
            ST_P11:   mac_op = '{32'({1'b0, bias_noise_reg}), dt_reg, sx34(p11_reg), 1'b0};
            ST_ERR:   mac_op = '{a_reg, ONE_Q, sx34(meas_reg), 1'b1};
            ST_PCT0:  mac_op = '{obs_gain_reg, p00_reg, 34'sd0, 1'b0};
            ST_PCT1:  mac_op = '{obs_gain_reg, p10_reg, 34'sd0, 1'b0};
            ST_E:     mac_op = '{obs_gain_reg, pct0_reg, 34'({1'b0, meas_noise_reg}), 1'b0};
            ST_T1:    mac_op = '{obs_gain_reg, p01_reg, 34'sd0, 1'b0};
            ST_C00:   mac_op = '{k0_reg, pct0_reg, sx34(p00_reg), 1'b1};
            ST_C01:   mac_op = '{k0_reg, tt_reg, sx34(p01_reg), 1'b1};
            ST_C10:   mac_op = '{k1_reg, pct0_reg, sx34(p10_reg), 1'b1};
            ST_C11:   mac_op = '{k1_reg, tt_reg, sx34(p11_reg), 1'b1};
            ST_CA:    mac_op = '{k0_reg, err_reg, sx34(a_reg), 1'b0};
            ST_CB:    mac_op = '{k1_reg, err_reg, sx34(b_reg), 1'b0};
            ST_RATE:  mac_op = '{b_reg, ONE_Q, sx34(gyro_reg), 1'b1};
            default:  mac_op = '0;
        endcase
    end

    kab_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start),
        .op      (mac_op),
        .done    (mac_done),
        .result  (mac_res)
    );

    kab_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (e_reg[30:0]),
        .done    (div_done),
        .quot    (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_noise_reg <= ANGLE_NOISE_RST;
            bias_noise_reg  <= BIAS_NOISE_RST;
            meas_noise_reg  <= MEAS_NOISE_RST;
            obs_gain_reg    <= OBS_GAIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_ANGLE_NOISE: angle_noise_reg <= cfg_wdata[30:0];
                CFG_BIAS_NOISE:  bias_noise_reg  <= cfg_wdata[30:0];
                CFG_MEAS_NOISE:  meas_noise_reg  <= cfg_wdata[30:0];
                CFG_OBS_GAIN:    obs_gain_reg    <= cfg_wdata;
                default:         obs_gain_reg    <= obs_gain_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= ST_GDIFF;
            m_valid_reg <= 1'b0;
            zero_reg    <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                est_angle_reg[i] <= '0;
                est_bias_reg[i]  <= '0;
                cov_aa_reg[i]    <= ONE_Q;
                cov_ab_reg[i]    <= '0;
                cov_ba_reg[i]    <= '0;
                cov_bb_reg[i]    <= ONE_Q;
            end
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        ch_reg   <= s_data.channel;
                        meas_reg <= s_data.angle_meas;
                        gyro_reg <= s_data.gyro_meas;
                        dt_reg   <= 32'({11'b0, s_data.step_time});
                        step_reg <= ST_GDIFF;
                        zero_reg <= !ch_ok;
                        if (ch_ok) begin
                            a_reg   <= est_angle_reg[s_data.channel];
                            b_reg   <= est_bias_reg[s_data.channel];
                            p00_reg <= cov_aa_reg[s_data.channel];
                            p01_reg <= cov_ab_reg[s_data.channel];
                            p10_reg <= cov_ba_reg[s_data.channel];
                            p11_reg <= cov_bb_reg[s_data.channel];
                            state_reg <= S_ISSUE;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_ISSUE: begin
                    state_reg <= div_start ? S_DIV : S_WAIT;
                end
                S_WAIT: begin
                    if (mac_done) begin
                        if (step_reg == ST_RATE) begin
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_ISSUE;
                        end
                        if (step_reg == ST_E && mac_res <= 0) begin
                            step_reg <= ST_RATE;
                        end else if (step_reg != ST_RATE) begin
                            step_reg <= step_t'(step_reg + 1'b1);
                        end
                        unique case (step_reg)
                            ST_GDIFF, ST_PD0:        t0_reg   <= mac_res;
                            ST_PD1:                  t1_reg   <= mac_res;
                            ST_APRED, ST_CA:         a_reg    <= mac_res;
                            ST_CB:                   b_reg    <= mac_res;
                            ST_P00, ST_C00:          p00_reg  <= mac_res;
                            ST_P01, ST_C01:          p01_reg  <= mac_res;
                            ST_P10, ST_C10:          p10_reg  <= mac_res;
                            ST_P11, ST_C11:          p11_reg  <= mac_res;
                            ST_ERR:                  err_reg  <= mac_res;
                            ST_PCT0:                 pct0_reg <= mac_res;
                            ST_PCT1:                 pct1_reg <= mac_res;
                            ST_T1:                   tt_reg   <= mac_res;
                            ST_E:                    e_reg    <= mac_res;
                            ST_RATE: begin
                                rate_reg <= mac_res;
                                est_angle_reg[ch_reg] <= a_reg;
                                est_bias_reg[ch_reg]  <= b_reg;
                                cov_aa_reg[ch_reg]    <= p00_reg;
                                cov_ab_reg[ch_reg]    <= p01_reg;
                                cov_ba_reg[ch_reg]    <= p10_reg;
                                cov_bb_reg[ch_reg]    <= p11_reg;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (step_reg == ST_K0) begin
                            k0_reg <= div_q;
                        end else begin
                            k1_reg <= div_q;
                        end
                        step_reg  <= step_t'(step_reg + 1'b1);
                        state_reg <= S_ISSUE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        m_data_reg <= zero_reg ? out_beat_t'('0)
                                               : out_beat_t'{a_reg, rate_reg};
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_mac_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> state_reg == S_WAIT)
        else $error("multiplier result outside wait state");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider result outside divide state");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("input ready right after accept");

endmodule
